// ----- src/ipv4dq_pkg.sv -----
package ipv4dq_pkg;

  // Character and octet limits
  localparam logic [7:0] DotCode    = 8'h2E;
  localparam logic [7:0] DigitLo    = 8'h30;
  localparam logic [7:0] DigitHi    = 8'h39;
  localparam int unsigned OctetW    = 9;
  localparam int unsigned CountW    = 2;
  localparam logic [OctetW-1:0] OctetMax = 9'd255;
  localparam logic [OctetW-1:0] OctetSat = 9'd256;
  localparam logic [CountW-1:0] DigitsMax  = 2'd3;
  localparam logic [CountW-1:0] DotsNeeded = 2'd3;

  // Character class of one input byte
  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_DOT,
    CLS_OTHER
  } char_class_e;

  // Running parse state for the current string
  typedef struct packed {
    logic [OctetW-1:0] octet_value;
    logic [CountW-1:0] digit_count;
    logic              first_digit_zero;
    logic [CountW-1:0] dot_count;
    logic              failed;
  } parse_state_t;

  localparam parse_state_t StateClear = '0;

  function automatic char_class_e classify(input logic [7:0] code);
    char_class_e cls;
    if (code >= DigitLo && code <= DigitHi) begin
      cls = CLS_DIGIT;
    end else if (code == DotCode) begin
      cls = CLS_DOT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// ----- src/ipv4dq_step.sv -----
module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t state_i,
  input  logic [7:0]               char_code_i,
  input  logic                     last_char_i,
  output ipv4dq_pkg::parse_state_t state_o,
  output logic                     is_valid_o
);
  import ipv4dq_pkg::*;

  localparam int unsigned ProdW = 12;

  char_class_e       cls;
  logic [3:0]        digit;
  logic [ProdW-1:0]  acc;
  parse_state_t      upd;

  assign cls   = classify(char_code_i);
  assign digit = 4'(char_code_i - DigitLo);
  // v*10 + d as (v<<3) + (v<<1) + d; v never exceeds 256
  assign acc   = (ProdW'(state_i.octet_value) << 3) + (ProdW'(state_i.octet_value) << 1)
               + ProdW'(digit);

  // Apply one character to the parse state
  always_comb begin
    upd = state_i;
    if (!state_i.failed) begin
      unique case (cls)
        CLS_DIGIT: begin
          if (state_i.digit_count >= DigitsMax) begin
            upd.failed = 1'b1;
          end else if (state_i.digit_count != '0 && state_i.first_digit_zero) begin
            upd.failed = 1'b1;
          end else begin
            if (state_i.digit_count == '0) begin
              upd.first_digit_zero = (digit == 4'd0);
            end
            upd.octet_value = (acc > ProdW'(OctetSat)) ? OctetSat : acc[OctetW-1:0];
            upd.digit_count = state_i.digit_count + 1'b1;
          end
        end
        CLS_DOT: begin
          if (state_i.digit_count == '0 || state_i.octet_value > OctetMax ||
              state_i.dot_count >= DotsNeeded) begin
            upd.failed = 1'b1;
          end else begin
            upd.dot_count        = state_i.dot_count + 1'b1;
            upd.octet_value      = '0;
            upd.digit_count      = '0;
            upd.first_digit_zero = 1'b0;
          end
        end
        default: begin
          upd.failed = 1'b1;
        end
      endcase
    end
  end

  // Verdict on the updated state; state clears at end of string
  assign is_valid_o = !upd.failed && upd.dot_count == DotsNeeded &&
                      upd.digit_count != '0 && upd.octet_value <= OctetMax;
  assign state_o    = last_char_i ? StateClear : upd;

endmodule

// ----- src/ipv4_dotted_quad_validator_core.sv -----
// An accepted last character passes the input and result registers to out_valid_o.
// Throughput: one character per cycle while not stalled; the parse-state update in
//   ipv4dq_step is the only loop and closes through the state_q register.
// Characters without the last flag produce no result beat.
// Reset (rst_ni low, asynchronous) empties the input and result registers and clears
//   the parse state.
module ipv4_dotted_quad_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_valid_o
);
  import ipv4dq_pkg::*;

  logic         in_vld_q;
  logic [7:0]   char_q;
  logic         last_q;
  parse_state_t state_q, state_d;
  logic         res_vld_q, res_vld_d;
  logic         res_q;
  logic         ok;
  logic         out_free;
  logic         advance;

  ipv4dq_step u_step (
    .state_i     (state_q),
    .char_code_i (char_q),
    .last_char_i (last_q),
    .state_o     (state_d),
    .is_valid_o  (ok)
  );

  // Handshake: a held beat moves on unless its result has nowhere to go
  assign out_free   = !res_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !advance;

  assign res_vld_d  = (advance && last_q) ? 1'b1 : (out_free ? 1'b0 : res_vld_q);

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= ok;
    end
  end

  assign out_valid_o = res_vld_q;
  assign is_valid_o  = res_q;

endmodule

// ----- src/ipv4dq_checker.sv -----
module ipv4dq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] char_code_i,
  input logic       last_char_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       is_valid_o
);
  import ipv4dq_pkg::*;

  logic bad_char;
  assign bad_char = !(char_code_i == DotCode ||
                      (char_code_i >= DigitLo && char_code_i <= DigitHi));

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_valid_o))
    else $error("result beat dropped or changed under stall");

  // Input never stalls when the result side can take a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while result register free");

  // A fresh result goes back to an accepted last character, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_char_i, 2))
    else $error("result beat without a last character");

  // A string ending on an illegal character is reported invalid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && $past(bad_char, 2) |-> !is_valid_o)
    else $error("illegal last character reported valid");

endmodule

bind ipv4_dotted_quad_validator_core ipv4dq_checker u_ipv4dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .char_code_i (char_code_i),
  .last_char_i (last_char_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .is_valid_o  (is_valid_o)
);

// ----- tb/ipv4_dotted_quad_validator_core_tb.sv -----
`timescale 1ns / 100ps

module ipv4_dotted_quad_validator_core_tb;
  import ipv4dq_pkg::*;

  localparam int RandItems  = 690;
  localparam int IdleLimit  = 2000;
  localparam int TailCycles = 6;
  localparam int NumDir     = 22;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_code_i;
  logic       last_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       is_valid_o;

  ipv4_dotted_quad_validator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_valid_o  (is_valid_o)
  );

  // Directed strings; '#' stands in for a NUL byte. Verdict -1: use the parser model.
  string dir_text [NumDir] = '{
    "0.0.0.0", "255.255.255.255", "1.2.3.4", "256.1.1.1", "1.2.3.999",
    "01.2.3.4", "1.2.3.00", "1234.1.1.1", "1..2.3", ".1.2.3", "1.2.3.",
    "1.2.3.4.5", "1.2.3.4.", "1.2.3", "1.2.3.4a", "1.#.3.4", "1.2.3.\377",
    "\200", "9", ".", "10.100.199.249", "7.08.1.2"
  };
  int dir_verdict [NumDir] = '{
    1, 1, 1, 0, 0,
    0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0,
    0, 0, 0, -1, -1
  };

  parse_state_t quad_st;
  logic         verdict_q[$];
  logic [7:0]   line_q[$];
  int           chars_sent;
  int           mismatches;
  int           results_seen;
  int           idle_cycles;
  int           tx_gap_pct;
  int           rx_stall_pct;
  logic         want_valid;

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Parser model: advance the running state by one character, report the verdict on last
  task automatic quad_parse_char(input logic [7:0] code, input logic last,
                                 output logic done, output logic ok);
    logic [3:0]  dig;
    logic [12:0] acc;
    done = 1'b0;
    ok   = 1'b0;
    if (!quad_st.failed) begin
      if (code >= DigitLo && code <= DigitHi) begin
        dig = 4'(code - DigitLo);
        if (quad_st.digit_count >= DigitsMax) begin
          quad_st.failed = 1'b1;
        end else if (quad_st.digit_count != 0 && quad_st.first_digit_zero) begin
          quad_st.failed = 1'b1;
        end else begin
          if (quad_st.digit_count == 0) quad_st.first_digit_zero = (dig == 0);
          acc = 13'(quad_st.octet_value * 10 + dig);
          quad_st.octet_value = (acc > OctetSat) ? OctetSat : acc[OctetW-1:0];
          quad_st.digit_count = quad_st.digit_count + 1'b1;
        end
      end else if (code == DotCode) begin
        if (quad_st.digit_count == 0 || quad_st.octet_value > OctetMax ||
            quad_st.dot_count >= DotsNeeded) begin
          quad_st.failed = 1'b1;
        end else begin
          quad_st.dot_count        = quad_st.dot_count + 1'b1;
          quad_st.octet_value      = '0;
          quad_st.digit_count      = '0;
          quad_st.first_digit_zero = 1'b0;
        end
      end else begin
        quad_st.failed = 1'b1;
      end
    end
    if (last) begin
      done = 1'b1;
      ok   = !quad_st.failed && quad_st.dot_count == DotsNeeded &&
             quad_st.digit_count != 0 && quad_st.octet_value <= OctetMax;
      quad_st = StateClear;
    end
  endtask

  // Drive one character beat, with random gaps before it, and log its expectation
  task automatic send_char(input logic [7:0] code, input logic last, input int verdict);
    logic done;
    logic ok;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    last_char_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    quad_parse_char(code, last, done, ok);
    if (done) verdict_q.push_back(verdict >= 0 ? verdict[0] : ok);
  endtask

  task automatic send_line(input int verdict);
    for (int i = 0; i < line_q.size(); i++) begin
      send_char(line_q[i], i == line_q.size() - 1, verdict);
    end
  endtask

  // Hold the sender off until every pending verdict has come back
  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly dotted quads with random octets and occasional damage, the rest byte noise
  task automatic build_random_line();
    int    r;
    int    v;
    int    pos;
    int    len;
    string oct;
    line_q.delete();
    if ($urandom_range(99) < 75) begin
      for (int k = 0; k < 4; k++) begin
        r = $urandom_range(99);
        if (r < 10) v = 0;
        else if (r < 20) v = 255;
        else if (r < 32) v = $urandom_range(999, 256);
        else v = $urandom_range(255);
        oct = $sformatf("%0d", v);
        for (int j = 0; j < oct.len(); j++) line_q.push_back(oct[j]);
        if (k < 3) line_q.push_back(DotCode);
      end
      if ($urandom_range(99) < 35) begin
        pos = $urandom_range(line_q.size() - 1);
        case ($urandom_range(5))
          0: line_q[pos] = 8'($urandom_range(255));
          1: line_q.insert(pos, 8'(DigitLo + $urandom_range(9)));
          2: line_q.insert(pos, DotCode);
          3: begin
            if (line_q.size() > 1) line_q.delete(pos);
          end
          4: line_q.push_front(DigitLo);
          default: begin
            if (line_q.size() > 1) void'(line_q.pop_back());
          end
        endcase
      end
    end else begin
      len = $urandom_range(10, 1);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 40) line_q.push_back(8'(DigitLo + $urandom_range(9)));
        else if (r < 60) line_q.push_back(DotCode);
        else line_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Receiver stall
  initial out_stall_i = 1'b0;
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d: unexpected beat, is_valid=%b",
                                       results_seen, is_valid_o);
      end else begin
        want_valid = verdict_q.pop_front();
        if (is_valid_o !== want_valid) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: is_valid expected %b got %b",
                                         results_seen, want_valid, is_valid_o);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int dir_chars;
    logic [7:0] code;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    char_code_i  = '0;
    last_char_i  = 1'b0;
    quad_st      = StateClear;
    chars_sent   = 0;
    mismatches   = 0;
    results_seen = 0;
    idle_cycles  = 0;
    tx_gap_pct   = 9;
    rx_stall_pct = 67;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings
    for (int n = 0; n < NumDir; n++) begin
      line_q.delete();
      for (int i = 0; i < dir_text[n].len(); i++) begin
        code = dir_text[n][i];
        line_q.push_back(code == "#" ? 8'h00 : code);
      end
      send_line(dir_verdict[n]);
    end
    dir_chars = chars_sent;

    // Random strings in three phases with different gap and stall rates, draining after each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_gap_pct   = 9;
          rx_stall_pct = 67;
        end
        1: begin
          tx_gap_pct   = 67;
          rx_stall_pct = 9;
        end
        default: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
      endcase
      while (chars_sent < dir_chars + (ph + 1) * RandItems / 3) begin
        build_random_line();
        send_line(-1);
      end
      drain_verdicts();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
